// ===== rtl/assert_macros.svh =====
// Assertion macros shared by ise_extremes and the top-level module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked assertion, also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/ise_pkg.sv =====
// Types, constants and arithmetic helpers of the sprite displacement estimator.
package ise_pkg;

   localparam int MAX_SPRITE_SIZE = 255;
   localparam int MIN_WALL        = 8;
   localparam int BYTE_MAX        = 255;

   typedef logic signed [17:0] key_type;
   typedef logic signed [13:0] geo_type;
   typedef logic [7:0]         coord_type;

   localparam key_type   KEY_HIGH     = 18'sd100000;
   localparam key_type   KEY_LOW      = -18'sd100000;
   localparam coord_type WIDTH_RESET  = 8'd64;
   localparam coord_type HEIGHT_RESET = 8'd64;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      coord_type lb_x;
      coord_type lb_y;
      coord_type rb_x;
      coord_type rb_y;
      coord_type lt_x;
      coord_type lt_y;
      coord_type rt_x;
      coord_type rt_y;
      coord_type min_col;
      coord_type max_col;
   } extremes_type;

   typedef struct packed {
      logic      valid;
      geo_type   top_x;
      geo_type   top_y;
      geo_type   bot_x;
      geo_type   bot_y;
      coord_type min_col;
      coord_type max_col;
      coord_type x;
      coord_type y;
   } corners_type;

   function automatic geo_type widen(coord_type c);
      return geo_type'({6'b0, c});
   endfunction

   // Signed divide by two, truncating toward zero.
   function automatic geo_type div2(geo_type v);
      geo_type t;
      t = v + geo_type'(v[13]);
      return t >>> 1;
   endfunction

   // Signed divide by four, truncating toward zero.
   function automatic geo_type div4(geo_type v);
      geo_type t;
      t = v + (v[13] ? geo_type'(3) : geo_type'(0));
      return t >>> 2;
   endfunction

endpackage

// ===== rtl/ise_extremes.sv =====
// Diagonal corner candidates and occupied column range of the loaded mask.
`include "assert_macros.svh"

module ise_extremes (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  ise_pkg::op_type      op,
   input  ise_pkg::coord_type   x,
   input  ise_pkg::coord_type   y,
   input  logic                 opaque,
   input  ise_pkg::coord_type   width,
   output ise_pkg::extremes_type ext
);

   ise_pkg::key_type lb_key_ff, rb_key_ff, lt_key_ff, rt_key_ff;
   ise_pkg::extremes_type ext_ff;
   ise_pkg::extremes_type ext_clear;
   ise_pkg::key_type lkey, rkey;
   logic do_clear, do_load;

   assign do_clear = item_valid && (op == ise_pkg::OP_CLEAR);
   assign do_load  = item_valid && (op == ise_pkg::OP_LOAD) && opaque;

   assign lkey = ise_pkg::key_type'({10'b0, x}) - ise_pkg::key_type'({9'b0, y, 1'b0});
   assign rkey = ise_pkg::key_type'({10'b0, width}) - ise_pkg::key_type'({10'b0, x})
               - ise_pkg::key_type'({9'b0, y, 1'b0});

   always_comb begin
      ext_clear         = '0;
      ext_clear.min_col = reset ? (ise_pkg::WIDTH_RESET - 8'd1) : (width - 8'd1);
   end

   always_ff @(posedge clock) begin
      if (reset || do_clear) begin
         lb_key_ff <= ise_pkg::KEY_HIGH;
         rb_key_ff <= ise_pkg::KEY_HIGH;
         lt_key_ff <= ise_pkg::KEY_LOW;
         rt_key_ff <= ise_pkg::KEY_LOW;
         ext_ff    <= ext_clear;
      end else if (do_load) begin
         if (lkey < lb_key_ff) begin
            lb_key_ff   <= lkey;
            ext_ff.lb_x <= x;
            ext_ff.lb_y <= y;
         end
         if (rkey < rb_key_ff) begin
            rb_key_ff   <= rkey;
            ext_ff.rb_x <= x;
            ext_ff.rb_y <= y;
         end
         if (rkey > lt_key_ff) begin
            lt_key_ff   <= rkey;
            ext_ff.lt_x <= x;
            ext_ff.lt_y <= y;
         end
         if (lkey > rt_key_ff) begin
            rt_key_ff   <= lkey;
            ext_ff.rt_x <= x;
            ext_ff.rt_y <= y;
         end
         if (x < ext_ff.min_col) ext_ff.min_col <= x;
         if (x > ext_ff.max_col) ext_ff.max_col <= x;
      end
   end

   assign ext = ext_ff;

   `ASSERT_CLK(a_lb_key_min, do_load |=> (lb_key_ff <= $past(lkey)),
               "left bottom key not minimal")
   `ASSERT_CLK(a_rt_key_max, do_load |=> (rt_key_ff >= $past(lkey)),
               "right top key not maximal")

endmodule

// ===== rtl/ise_corners.sv =====
// Top and bottom corner derivation stage of a displacement query.
module ise_corners (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  query_valid,
   input  ise_pkg::coord_type    x,
   input  ise_pkg::coord_type    y,
   input  ise_pkg::extremes_type ext,
   output ise_pkg::corners_type  crn
);

   ise_pkg::geo_type d_top, d_bot, rtx, rty, rbx, rby;
   ise_pkg::corners_type crn_in, crn_ff;

   always_comb begin
      d_top = ise_pkg::widen(ext.rt_y) - ise_pkg::widen(ext.lt_y);
      rtx   = ise_pkg::widen(ext.rt_x) - (d_top <<< 1);
      rty   = ise_pkg::widen(ext.rt_y) - d_top;
      d_bot = ise_pkg::widen(ext.rb_y) - ise_pkg::widen(ext.lb_y);
      rbx   = ise_pkg::widen(ext.rb_x) - (d_bot <<< 1);
      rby   = ise_pkg::widen(ext.rb_y) - d_bot;

      crn_in.valid   = query_valid;
      crn_in.top_x   = ise_pkg::div2(rtx + ise_pkg::widen(ext.lt_x));
      crn_in.bot_x   = ise_pkg::div2(rbx + ise_pkg::widen(ext.lb_x));
      crn_in.top_y   = rty - ise_pkg::div4(rtx - ise_pkg::widen(ext.lt_x));
      crn_in.bot_y   = rby + ise_pkg::div4(rbx - ise_pkg::widen(ext.lb_x));
      crn_in.min_col = ext.min_col;
      crn_in.max_col = ext.max_col;
      crn_in.x       = x;
      crn_in.y       = y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crn_ff.valid <= 1'b0;
      end else begin
         crn_ff.valid <= crn_in.valid;
      end
      crn_ff.top_x   <= crn_in.top_x;
      crn_ff.top_y   <= crn_in.top_y;
      crn_ff.bot_x   <= crn_in.bot_x;
      crn_ff.bot_y   <= crn_in.bot_y;
      crn_ff.min_col <= crn_in.min_col;
      crn_ff.max_col <= crn_in.max_col;
      crn_ff.x       <= crn_in.x;
      crn_ff.y       <= crn_in.y;
   end

   assign crn = crn_ff;

endmodule

// ===== rtl/ise_displace.sv =====
// Wall height and clamped displacement stage with the result register.
module ise_displace (
   input  logic                 clock,
   input  logic                 reset,
   input  ise_pkg::corners_type crn,
   input  ise_pkg::coord_type   height,
   output logic                 strobe,
   output ise_pkg::coord_type   push_left,
   output ise_pkg::coord_type   push_right,
   output ise_pkg::coord_type   lift
);

   ise_pkg::geo_type lw, rw, wall_raw, wall, wall2, lim, dx, adx, dy, excess, min_c, max_c;
   ise_pkg::coord_type pl0, pr0, pl_in, pr_in, lf_in;
   ise_pkg::coord_type pl_ff, pr_ff, lf_ff;
   logic strobe_ff;

   function automatic ise_pkg::coord_type clamp_byte(ise_pkg::geo_type v, ise_pkg::geo_type hi);
      ise_pkg::coord_type r;
      if (v < 0) r = '0;
      else if (v > hi) r = hi[7:0];
      else r = v[7:0];
      return r;
   endfunction

   always_comb begin
      min_c = ise_pkg::widen(crn.min_col);
      max_c = ise_pkg::widen(crn.max_col);
      lw = (crn.bot_y - ise_pkg::div2(crn.bot_x - min_c))
         - (crn.top_y + ise_pkg::div2(crn.top_x - min_c));
      rw = (crn.bot_y - ise_pkg::div2(max_c - crn.bot_x))
         - (crn.top_y + ise_pkg::div2(max_c - crn.top_x));
      wall_raw = (lw < rw) ? lw : rw;
      wall  = (wall_raw < ise_pkg::geo_type'(ise_pkg::MIN_WALL)) ? '0 : wall_raw;
      wall2 = wall <<< 1;
      lim   = (wall < ise_pkg::geo_type'(ise_pkg::BYTE_MAX)) ? wall
                                                            : ise_pkg::geo_type'(ise_pkg::BYTE_MAX);

      dx  = crn.bot_x - ise_pkg::widen(crn.x);
      adx = (dx < 0) ? -dx : dx;
      dy  = (((ise_pkg::widen(height) - ise_pkg::geo_type'(1)) - ise_pkg::widen(crn.y)) <<< 1)
          - adx;
      excess = dy - wall2;

      pl0   = clamp_byte(-(dx <<< 1), ise_pkg::geo_type'(ise_pkg::BYTE_MAX));
      pr0   = clamp_byte(dx <<< 1, ise_pkg::geo_type'(ise_pkg::BYTE_MAX));
      lf_in = clamp_byte(ise_pkg::div2(dy), lim);
      if (dy > wall2) begin
         pl_in = clamp_byte(ise_pkg::widen(pl0) + excess, ise_pkg::geo_type'(ise_pkg::BYTE_MAX));
         pr_in = clamp_byte(ise_pkg::widen(pr0) + excess, ise_pkg::geo_type'(ise_pkg::BYTE_MAX));
      end else begin
         pl_in = pl0;
         pr_in = pr0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= crn.valid;
      end
   end

   always_ff @(posedge clock) begin
      pl_ff <= pl_in;
      pr_ff <= pr_in;
      lf_ff <= lf_in;
   end

   assign strobe     = strobe_ff;
   assign push_left  = pl_ff;
   assign push_right = pr_ff;
   assign lift       = lf_ff;

endmodule

// ===== rtl/isometric_sprite_displacement_estimator.sv =====
// Top level of the isometric sprite displacement estimator.
//
// Usage:
//   Input channel: an item (req_op, req_pixel_x, req_pixel_y, req_pixel_opaque)
//   is taken at each rising edge with start high and busy low. busy stays low,
//   so one item is taken every cycle.
//   Ops: clear resets the corner candidates and column range, load updates them
//   from an opaque pixel, query returns one result. Other codes are dropped.
//   Result channel: rsp_strobe is high for one cycle with rsp_push_left,
//   rsp_push_right and rsp_lift; the receiver cannot stall and must take it.
//   Pipeline: a query passes through the input register, the corner stage and
//   the result register, in that order. Throughput is one item per cycle; a
//   query sees every load and clear taken before it.
//   Configuration: csr_write_enable writes csr_data to the register chosen by
//   csr_index (0 width, 1 height); other indexes are ignored. Write only while
//   no item is in flight.
//   Reset: synchronous; width and height return to 64, the extremes clear and
//   the pipeline empties.
`include "assert_macros.svh"

module isometric_sprite_displacement_estimator (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [7:0] req_pixel_x,
   input  logic [7:0] req_pixel_y,
   input  logic       req_pixel_opaque,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   output logic       rsp_strobe,
   output logic [7:0] rsp_push_left,
   output logic [7:0] rsp_push_right,
   output logic [7:0] rsp_lift
);

   ise_pkg::coord_type width_ff, height_ff, csr_value;
   logic valid_ff, valid_in;
   ise_pkg::op_type op_ff;
   ise_pkg::coord_type x_ff, y_ff;
   logic opaque_ff;
   ise_pkg::extremes_type ext;
   ise_pkg::corners_type crn;

   assign busy     = 1'b0;
   assign valid_in = start && !busy;
   assign csr_value = (csr_data > ise_pkg::coord_type'(ise_pkg::MAX_SPRITE_SIZE))
                    ? ise_pkg::coord_type'(ise_pkg::MAX_SPRITE_SIZE) : csr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= ise_pkg::WIDTH_RESET;
         height_ff <= ise_pkg::HEIGHT_RESET;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               ise_pkg::CSR_WIDTH:  width_ff  <= csr_value;
               ise_pkg::CSR_HEIGHT: height_ff <= csr_value;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         op_ff     <= ise_pkg::op_type'(req_op);
         x_ff      <= req_pixel_x;
         y_ff      <= req_pixel_y;
         opaque_ff <= req_pixel_opaque;
      end
   end

   ise_extremes u_extremes (
      .clock      (clock),
      .reset      (reset),
      .item_valid (valid_ff),
      .op         (op_ff),
      .x          (x_ff),
      .y          (y_ff),
      .opaque     (opaque_ff),
      .width      (width_ff),
      .ext        (ext)
   );

   ise_corners u_corners (
      .clock       (clock),
      .reset       (reset),
      .query_valid (valid_ff && (op_ff == ise_pkg::OP_QUERY)),
      .x           (x_ff),
      .y           (y_ff),
      .ext         (ext),
      .crn         (crn)
   );

   ise_displace u_displace (
      .clock      (clock),
      .reset      (reset),
      .crn        (crn),
      .height     (height_ff),
      .strobe     (rsp_strobe),
      .push_left  (rsp_push_left),
      .push_right (rsp_push_right),
      .lift       (rsp_lift)
   );

   `ASSERT_CLK(a_query_result,
               (start && !busy && req_op == ise_pkg::OP_QUERY) |-> ##3 rsp_strobe,
               "query item gave no result")
   `ASSERT_CLK(a_other_silent,
               (!(start && !busy) || req_op != ise_pkg::OP_QUERY) |-> ##3 !rsp_strobe,
               "result without a query item")

endmodule
